/* rtl/etl_pkg.sv */
// Shared definitions for the expression token lexer: token kinds, run modes,
// character classes and the token record that moves through the result queue.
// No dependencies.
package etl_pkg;

    // Token kinds
    localparam logic [3:0] K_EOI     = 4'd0;
    localparam logic [3:0] K_UNKNOWN = 4'd1;
    localparam logic [3:0] K_IDENT   = 4'd2;
    localparam logic [3:0] K_NUMBER  = 4'd3;
    localparam logic [3:0] K_WITH    = 4'd4;
    localparam logic [3:0] K_PLUS    = 4'd5;
    localparam logic [3:0] K_MINUS   = 4'd6;
    localparam logic [3:0] K_STAR    = 4'd7;
    localparam logic [3:0] K_SLASH   = 4'd8;
    localparam logic [3:0] K_LPAREN  = 4'd9;
    localparam logic [3:0] K_RPAREN  = 4'd10;
    localparam logic [3:0] K_COLON   = 4'd11;
    localparam logic [3:0] K_COMMA   = 4'd12;

    // Run modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Keyword tracker: 0..4 letters matched, dead once the run diverges
    localparam logic [2:0] KW_FULL = 3'd4;
    localparam logic [2:0] KW_DEAD = 3'd5;

    // Default width of the position counters
    localparam int POS_WIDTH_DEFAULT = 16;

    // Result queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // One token as delivered on the output stream
    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] start;
        logic [3:0]  kind;
    } t_token;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Letters of the keyword "with"
    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h77;
            2'd1:    ch = 8'h69;
            2'd2:    ch = 8'h74;
            default: ch = 8'h68;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h3A:   k = K_COLON;
            8'h2C:   k = K_COMMA;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

/* rtl/etl_tok_queue.sv */
// Small result queue for the lexer: takes zero, one or two tokens per cycle
// and hands them out one per transaction. Depends on etl_pkg.
module etl_tok_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_cnt,
    input  etl_pkg::t_token i_push_tok0,
    input  etl_pkg::t_token i_push_tok1,
    input  logic            i_pop,
    output etl_pkg::t_token o_head,
    output logic            o_valid,
    output logic [$clog2(etl_pkg::QUEUE_DEPTH):0] o_count
);
    import etl_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_token          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]     r_count, n_count;
    logic            pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + AW'(pop_ok);
        n_count  = r_count + (AW+1)'(i_push_cnt) - (AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed tokens in order
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push_tok1;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_count <= (AW+1)'(QUEUE_DEPTH);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("token queue overflow");

    property p_ptr_gap;
        @(posedge i_clk) disable iff (!i_rst_n)
            AW'(r_wr_ptr - r_rd_ptr) == r_count[AW-1:0];
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers and count disagree");

    property p_push_count;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_push_cnt == 2'd2 && !pop_ok) |=> r_count == $past(r_count) + (AW+1)'(2);
    endproperty
    a_push_count: assert property (p_push_count) else $error("double push lost an entry");

endmodule

/* rtl/expression_token_lexer.sv */
// Top level of the expression token lexer: classifies each source byte,
// tracks identifier and number runs, and queues tokens for output.
// Depends on etl_pkg and etl_tok_queue.
//
// Usage:
//   s_axis carries source text, one byte per transaction in s_axis_tdata;
//   a zero byte ends the text. m_axis carries tokens: tdata holds kind,
//   start offset and length; tlast marks the final token caused by a byte.
//   Whitespace and bytes that extend a run produce no token; a byte that
//   ends a run produces the run token and possibly its own token.
// Throughput: one byte per cycle. The byte is lexed in one combinational
//   pass into a four-entry token queue; s_axis_tready is high while the
//   queue holds two tokens or fewer, so a downstream stall or a run of
//   bytes giving two tokens each fills the queue and holds input back.
// Reset: clears run state, text position and the queue; no clearing pass.
//   A zero byte returns the position and run state to the same values.
module expression_token_lexer #(
    parameter int POSITION_WIDTH = etl_pkg::POS_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                        // [35:20] token_length, [39:36] zero
    output logic        m_axis_tlast    // last_of_run
);
    import etl_pkg::*;

    localparam int P  = POSITION_WIDTH;
    localparam int QW = $clog2(QUEUE_DEPTH);

    logic [1:0]   r_mode,  n_mode;
    logic [P-1:0] r_start, n_start;
    logic [P-1:0] r_len,   n_len;
    logic [2:0]   r_kw,    n_kw;
    logic [P-1:0] r_pos,   n_pos;

    logic [7:0]   c;
    logic         accept;
    logic         cont_ident, cont_num, closing, emit_own;
    t_token       tok_run, tok_own, tok0, tok1;
    logic [1:0]   push_cnt;
    t_token       head;
    logic [QW:0]  q_count;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (&v) ? v : v + P'(1);
    endfunction

    // Clip a position value to the 16-bit output field
    function automatic logic [15:0] clip16(input logic [P-1:0] v);
        logic [P+15:0] ext;
        ext = {16'b0, v};
        return (|ext[P+15:16]) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic logic [2:0] track_kw(input logic [2:0] kw, input logic [7:0] ch);
        logic [2:0] res;
        if (kw < KW_FULL && ch == kw_char(kw[1:0])) begin
            res = kw + 3'd1;
        end else begin
            res = KW_DEAD;
        end
        return res;
    endfunction

    assign c        = s_axis_tdata;
    assign s_axis_tready = (q_count <= (QW+1)'(QUEUE_DEPTH - 2));
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign cont_ident = (r_mode == MODE_IDENT) && is_letter(c);
    assign cont_num   = (r_mode == MODE_NUMBER) && is_digit(c);
    assign closing    = (r_mode != MODE_IDLE) && !cont_ident && !cont_num;
    assign emit_own   = !cont_ident && !cont_num && !is_space(c)
                        && !is_letter(c) && !is_digit(c);

    // Lex one byte: next run state and the tokens it produces
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_kw    = r_kw;
        n_pos   = sat_inc(r_pos);

        tok_run.kind   = (r_mode == MODE_NUMBER) ? K_NUMBER :
                         (r_kw == KW_FULL) ? K_WITH : K_IDENT;
        tok_run.start  = clip16(r_start);
        tok_run.length = clip16(r_len);
        tok_run.last   = !emit_own;

        tok_own.kind   = (c == 8'h00) ? K_EOI : punct_kind(c);
        tok_own.start  = clip16(r_pos);
        tok_own.length = (c == 8'h00) ? 16'd0 : 16'd1;
        tok_own.last   = 1'b1;

        if (cont_ident) begin
            n_len = sat_inc(r_len);
            n_kw  = track_kw(r_kw, c);
        end else if (cont_num) begin
            n_len = sat_inc(r_len);
        end else begin
            if (closing) begin
                n_mode = MODE_IDLE;
                n_len  = '0;
                n_kw   = 3'd0;
            end
            if (c == 8'h00) begin
                n_mode  = MODE_IDLE;
                n_start = '0;
                n_len   = '0;
                n_kw    = 3'd0;
                n_pos   = '0;
            end else if (is_letter(c)) begin
                n_mode  = MODE_IDENT;
                n_start = r_pos;
                n_len   = P'(1);
                n_kw    = track_kw(3'd0, c);
            end else if (is_digit(c)) begin
                n_mode  = MODE_NUMBER;
                n_start = r_pos;
                n_len   = P'(1);
                n_kw    = 3'd0;
            end
        end

        // Order the tokens: run token first, then the byte's own token
        tok0 = closing ? tok_run : tok_own;
        tok1 = tok_own;
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = 2'(closing) + 2'(emit_own);
        end
    end

    // Hold run state; update only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_kw    <= 3'd0;
            r_pos   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_kw    <= n_kw;
            r_pos   <= n_pos;
        end
    end

    etl_tok_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_tok0 (tok0),
        .i_push_tok1 (tok1),
        .i_pop       (m_axis_tready),
        .o_head      (head),
        .o_valid     (m_axis_tvalid),
        .o_count     (q_count)
    );

    assign m_axis_tdata = {4'b0, head.length, head.start, head.kind};
    assign m_axis_tlast = head.last;

    property p_eoi_resets;
        @(posedge i_clk) disable iff (!i_rst_n)
            (accept && c == 8'h00) |=> (r_pos == '0 && r_mode == MODE_IDLE);
    endproperty
    a_eoi_resets: assert property (p_eoi_resets) else $error("end of text did not reset");

    property p_idle_len;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_mode == MODE_IDLE) |-> (r_len == '0 && r_kw == 3'd0);
    endproperty
    a_idle_len: assert property (p_idle_len) else $error("idle lexer holds run data");

    property p_run_len;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) |-> r_len != '0;
    endproperty
    a_run_len: assert property (p_run_len) else $error("open run with zero length");

    property p_kw_only_ident;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_mode != MODE_IDENT) |-> r_kw == 3'd0;
    endproperty
    a_kw_only_ident: assert property (p_kw_only_ident) else $error("keyword state outside run");

endmodule
